// ===== design/wat_pkg.sv =====
package wat_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int LEN_W      = 13;
    localparam int THR_W      = 15;

    localparam logic [LEN_W-1:0] LEN_RST  = 13'd4096;
    localparam logic [THR_W-1:0] THR_RST  = 15'd29491;
    localparam logic             MODE_RST = 1'b1;

    typedef enum logic [1:0] {
        REG_LEN  = 2'd0,
        REG_THR  = 2'd1,
        REG_MODE = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_FINAL,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic take;      // latch request, start store read
        logic fill;      // window still filling
        logic update;    // replace oldest, load divider
        logic div_step;
        logic finish;    // sign fix, threshold check
        logic push;      // load output register
    } t_dp_cmd;

    typedef struct packed {
        logic filling;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== design/wat_if.sv =====
interface wat_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface wat_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          average_valid;
    logic                          event_res;

    modport source (output valid, output average, output average_valid,
                    output event_res, input ready);
    modport sink   (input valid, input average, input average_valid,
                    input event_res, output ready);
endinterface

// ===== design/wat_regs.sv =====
module wat_regs #(
    parameter int WINDOW_MAX = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wat_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [wat_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [wat_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    output logic [$clog2(WINDOW_MAX+1)-1:0]    o_eff_len,
    output logic [wat_pkg::THR_W-1:0]          o_thr,
    output logic                               o_above,
    output logic                               o_len_wr
);
    localparam int LW = $clog2(WINDOW_MAX + 1);

    logic [wat_pkg::LEN_W-1:0] r_len;
    logic [wat_pkg::THR_W-1:0] r_thr;
    logic                      r_above;
    logic                      wr_en;
    wat_pkg::t_reg_idx         idx;
    logic [31:0]               len_x;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = wat_pkg::t_reg_idx'(paddr[wat_pkg::CFG_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= wat_pkg::LEN_RST;
            r_thr   <= wat_pkg::THR_RST;
            r_above <= wat_pkg::MODE_RST;
        end else if (wr_en) begin
            case (idx)
                wat_pkg::REG_LEN:  r_len   <= pwdata[wat_pkg::LEN_W-1:0];
                wat_pkg::REG_THR:  r_thr   <= pwdata[wat_pkg::THR_W-1:0];
                wat_pkg::REG_MODE: r_above <= pwdata[0];
                default: ;
            endcase
        end
    end

    assign o_len_wr = wr_en && (idx == wat_pkg::REG_LEN);

    always_comb begin
        case (idx)
            wat_pkg::REG_LEN:  prdata = wat_pkg::CFG_DATA_W'(r_len);
            wat_pkg::REG_THR:  prdata = wat_pkg::CFG_DATA_W'(r_thr);
            wat_pkg::REG_MODE: prdata = wat_pkg::CFG_DATA_W'(r_above);
            default:           prdata = '0;
        endcase
    end

    // zero length acts as one, oversize saturates
    assign len_x = 32'(r_len);
    always_comb begin
        if (r_len == '0) begin
            o_eff_len = LW'(1);
        end else if (len_x > 32'(WINDOW_MAX)) begin
            o_eff_len = LW'(WINDOW_MAX);
        end else begin
            o_eff_len = len_x[LW-1:0];
        end
    end

    assign o_thr   = r_thr;
    assign o_above = r_above;

endmodule

// ===== design/wat_ctrl.sv =====
module wat_ctrl #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  wat_pkg::t_dp_sts i_sts,
    output wat_pkg::t_dp_cmd o_cmd
);
    localparam int CW = $clog2(SAMPLE_BITS);

    wat_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wat_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            wat_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = wat_pkg::ST_UPDATE;
                end
            end
            wat_pkg::ST_UPDATE: begin
                n_cnt = '0;
                if (i_sts.filling) begin
                    o_cmd.fill = 1'b1;
                    n_state    = wat_pkg::ST_PUSH;
                end else begin
                    o_cmd.update = 1'b1;
                    n_state      = wat_pkg::ST_DIV;
                end
            end
            wat_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CW'(1);
                if (r_cnt == CW'(SAMPLE_BITS - 1)) begin
                    n_state = wat_pkg::ST_FINAL;
                end
            end
            wat_pkg::ST_FINAL: begin
                o_cmd.finish = 1'b1;
                n_state      = wat_pkg::ST_PUSH;
            end
            wat_pkg::ST_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = wat_pkg::ST_IDLE;
                end
            end
            default: n_state = wat_pkg::ST_IDLE;
        endcase
    end

    a_div_before_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wat_pkg::ST_FINAL) |-> ($past(r_state) == wat_pkg::ST_DIV))
        else $error("final step not preceded by divide");

endmodule

// ===== design/wat_dp.sv =====
module wat_dp #(
    parameter int WINDOW_MAX  = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wat_pkg::t_dp_cmd                  i_cmd,
    output wat_pkg::t_dp_sts                  o_sts,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]   i_eff_len,
    input  logic [wat_pkg::THR_W-1:0]         i_thr,
    input  logic                              i_above,
    input  logic                              i_len_wr,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic signed [SAMPLE_BITS-1:0]     o_average,
    output logic                              o_average_valid,
    output logic                              o_event_res
);
    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int LW    = $clog2(WINDOW_MAX + 1);
    localparam int SW    = SB + AW;
    localparam int CMP_W = 33;

    logic signed [SB-1:0] r_mem [WINDOW_MAX];
    logic signed [SB-1:0] r_smp;
    logic signed [SB-1:0] r_old;
    logic [AW-1:0]        r_wp;
    logic [LW-1:0]        r_fill;
    logic signed [SW-1:0] r_sum;
    logic                 r_neg;
    logic [LW-1:0]        r_rem;
    logic [SB-1:0]        r_dq;
    logic signed [SB-1:0] r_avg;
    logic                 r_seen;
    logic                 r_event;
    logic                 r_ov;
    logic signed [SB-1:0] r_avg_o;
    logic                 r_seen_o;
    logic                 r_evt_o;

    logic signed [SW-1:0] s_ext, old_ext, sum_fill, sum_upd;
    logic [SW-1:0]        mag_upd;
    logic [LW-1:0]        wp_inc;
    logic [AW-1:0]        wp_next;
    logic [LW:0]          trial, len_x, diff;
    logic                 ge;
    logic [LW-1:0]        rem_step;
    logic [SB-1:0]        mean_v;
    logic [CMP_W-1:0]     q_ext, thr_ext;
    logic                 hit;

    assign s_ext    = {{AW{r_smp[SB-1]}}, r_smp};
    assign old_ext  = {{AW{r_old[SB-1]}}, r_old};
    assign sum_fill = r_sum + s_ext;
    assign sum_upd  = r_sum - old_ext + s_ext;
    assign mag_upd  = sum_upd[SW-1] ? SW'(-sum_upd) : SW'(sum_upd);

    assign wp_inc  = LW'(r_wp) + LW'(1);
    assign wp_next = (wp_inc == i_eff_len) ? '0 : wp_inc[AW-1:0];

    // restoring divide, one quotient bit per step; the remainder stays below length
    assign trial    = {r_rem, r_dq[SB-1]};
    assign len_x    = {1'b0, i_eff_len};
    assign ge       = (trial >= len_x);
    assign diff     = trial - len_x;
    assign rem_step = ge ? diff[LW-1:0] : trial[LW-1:0];

    assign mean_v  = r_neg ? (~r_dq + SB'(1)) : r_dq;
    assign q_ext   = CMP_W'(r_dq);
    assign thr_ext = CMP_W'(i_thr);
    assign hit     = i_above ? (q_ext > thr_ext) : (q_ext < thr_ext);

    assign o_sts.filling  = (r_fill < i_eff_len);
    assign o_sts.out_free = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill || i_cmd.update) begin
            r_mem[r_wp] <= r_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_old <= r_mem[r_wp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_smp <= i_sample;
        end
        if (i_cmd.update) begin
            r_neg <= sum_upd[SW-1];
            r_rem <= LW'(mag_upd[SW-1:SB]);
            r_dq  <= mag_upd[SB-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= rem_step;
            r_dq  <= {r_dq[SB-2:0], ge};
        end
        if (i_cmd.push) begin
            r_avg_o  <= r_avg;
            r_seen_o <= r_seen;
            r_evt_o  <= r_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_avg   <= '0;
            r_seen  <= 1'b0;
            r_event <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_len_wr) begin
                r_wp   <= '0;
                r_fill <= '0;
                r_sum  <= '0;
            end else if (i_cmd.fill) begin
                r_wp   <= wp_next;
                r_fill <= r_fill + LW'(1);
                r_sum  <= sum_fill;
            end else if (i_cmd.update) begin
                r_wp  <= wp_next;
                r_sum <= sum_upd;
            end
            if (i_cmd.finish) begin
                r_avg  <= $signed(mean_v);
                r_seen <= 1'b1;
                if (hit) begin
                    r_event <= 1'b1;
                end
            end
            if (i_cmd.push) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_ov;
    assign o_average       = r_avg_o;
    assign o_average_valid = r_seen_o;
    assign o_event_res     = r_evt_o;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= i_eff_len)
        else $error("fill count beyond window length");

    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_wp) < i_eff_len)
        else $error("write pointer beyond window length");

    a_event_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_event |=> r_event)
        else $error("event flag cleared");

    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |=> r_seen)
        else $error("mean valid mark cleared");

endmodule

// ===== design/windowed_average_threshold_detector.sv =====
// A request is taken only in the idle state; in the mean phase it passes the update,
// divide, final and push states, while the window fills it goes from update to push.
// Push waits while the output register still holds an untaken result, and no new request
// is taken before push; the restoring divider gives one quotient bit per cycle.
// Synchronous active-low reset clears window state, mean, flags and restores the
// register defaults; the sample store holds no reset and needs no clearing pass.
module windowed_average_threshold_detector #(
    parameter int WINDOW_MAX  = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    wat_in_if.sink                         i_smp,
    wat_out_if.source                      o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wat_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [wat_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [wat_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    localparam int LW = $clog2(WINDOW_MAX + 1);

    logic [LW-1:0]             eff_len;
    logic [wat_pkg::THR_W-1:0] thr;
    logic                      above;
    logic                      len_wr;
    wat_pkg::t_dp_cmd          cmd;
    wat_pkg::t_dp_sts          sts;

    wat_regs #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_eff_len (eff_len),
        .o_thr     (thr),
        .o_above   (above),
        .o_len_wr  (len_wr)
    );

    wat_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (i_smp.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wat_dp #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_sample        (i_smp.sample),
        .i_eff_len       (eff_len),
        .i_thr           (thr),
        .i_above         (above),
        .i_len_wr        (len_wr),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_average       (o_res.average),
        .o_average_valid (o_res.average_valid),
        .o_event_res     (o_res.event_res)
    );

endmodule

// ===== tb/tb_windowed_average_threshold_detector.sv =====
module tb_windowed_average_threshold_detector;

    localparam int WINDOW_MAX  = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // Tracks window contents and sticky flag; queues one expected result per request.
    class mean_tracker;
        typedef struct {
            t_sample average;
            logic    average_valid;
            logic    event_res;
        } t_mean_result;

        logic [wat_pkg::LEN_W-1:0] len_reg;
        logic [wat_pkg::THR_W-1:0] thr_reg;
        logic                      above_reg;

        t_sample     ring [WINDOW_MAX];
        int unsigned wr_ptr;
        int unsigned fill_cnt;
        longint      sum;
        t_sample     last_mean;
        bit          mean_seen;
        bit          event_hit;

        t_mean_result expected_means[$];
        int           mismatches;
        int           samples_taken;
        int           means_taken;

        function new();
            len_reg       = wat_pkg::LEN_RST;
            thr_reg       = wat_pkg::THR_RST;
            above_reg     = wat_pkg::MODE_RST;
            wr_ptr        = 0;
            fill_cnt      = 0;
            sum           = 0;
            last_mean     = '0;
            mean_seen     = 0;
            event_hit     = 0;
            mismatches    = 0;
            samples_taken = 0;
            means_taken   = 0;
        endfunction

        function void write_reg(wat_pkg::t_reg_idx idx,
                                logic [wat_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                wat_pkg::REG_LEN: begin
                    len_reg  = value[wat_pkg::LEN_W-1:0];
                    wr_ptr   = 0;
                    fill_cnt = 0;
                    sum      = 0;
                end
                wat_pkg::REG_THR:  thr_reg   = value[wat_pkg::THR_W-1:0];
                wat_pkg::REG_MODE: above_reg = value[0];
                default: ;
            endcase
        endfunction

        function int unsigned window_size();
            if (len_reg == 0) return 1;
            if (len_reg > WINDOW_MAX) return WINDOW_MAX;
            return len_reg;
        endfunction

        function void note_sample(t_sample s);
            int unsigned  n;
            int unsigned  slot;
            longint       mean;
            longint       mag;
            t_mean_result r;
            n    = window_size();
            slot = wr_ptr % n;
            if (fill_cnt < n) begin
                ring[slot] = s;
                sum += s;
                fill_cnt++;
            end else begin
                sum -= ring[slot];
                ring[slot] = s;
                sum += s;
                mean = sum / longint'(n);   // truncates toward zero
                mag  = (mean < 0) ? -mean : mean;
                last_mean = t_sample'(mean);
                mean_seen = 1;
                means_taken++;
                if (above_reg) begin
                    if (mag > longint'(thr_reg)) event_hit = 1;
                end else begin
                    if (mag < longint'(thr_reg)) event_hit = 1;
                end
            end
            wr_ptr = (slot + 1) % n;
            samples_taken++;
            r.average       = last_mean;
            r.average_valid = mean_seen;
            r.event_res     = event_hit;
            expected_means.insert(expected_means.size(), r);
        endfunction

        function void check_result(t_sample avg, logic avg_valid, logic ev);
            t_mean_result r;
            if (expected_means.size() == 0) begin
                $error("unexpected result: average=%0d average_valid=%0b event_res=%0b",
                       avg, avg_valid, ev);
                mismatches++;
                return;
            end
            r = expected_means[0];
            expected_means.delete(0);
            if (avg !== r.average) begin
                $error("average: expected %0d, got %0d", r.average, avg);
                mismatches++;
            end
            if (avg_valid !== r.average_valid) begin
                $error("average_valid: expected %0b, got %0b", r.average_valid, avg_valid);
                mismatches++;
            end
            if (ev !== r.event_res) begin
                $error("event_res: expected %0b, got %0b", r.event_res, ev);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_means.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [wat_pkg::CFG_ADDR_W-1:0] paddr;
    logic [wat_pkg::CFG_DATA_W-1:0] pwdata;
    logic [wat_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    wat_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) smp_if ();
    wat_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) res_if ();

    windowed_average_threshold_detector #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mean_tracker tracker = new();

    t_sample sample_queue[$];
    int      send_idle_pct   = 0;
    int      recv_stall_pct  = 0;
    bit      hold_off_req    = 0;
    int      reg_errors      = 0;
    int      settings_used   = 0;
    int      cycle_count     = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, tracker.outstanding());
        $display("windowed_average_threshold_detector verification failed");
        $finish;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            tracker.check_result(res_if.average, res_if.average_valid, res_if.event_res);
        end
    end

    function automatic int gap_cycles();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if ($urandom_range(0, 99) < recv_stall_pct) begin
                res_if.ready <= 1'b0;
                repeat (gap_cycles()) @(negedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic feed_samples();
        int gap;
        @(negedge i_clk);
        while (sample_queue.size() > 0) begin
            gap = ($urandom_range(0, 99) < send_idle_pct) ? gap_cycles() : 0;
            if (gap > 0) begin
                smp_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            smp_if.valid  <= 1'b1;
            smp_if.sample <= sample_queue[0];
            sample_queue.delete(0);
            do @(posedge i_clk); while (!smp_if.ready);
            tracker.note_sample(smp_if.sample);
            @(negedge i_clk);
        end
        smp_if.valid <= 1'b0;
    endtask

    task automatic reg_write(input wat_pkg::t_reg_idx idx,
                             input logic [wat_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.write_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_check(input wat_pkg::t_reg_idx idx,
                             input logic [wat_pkg::CFG_DATA_W-1:0] exp_val);
        logic [wat_pkg::CFG_DATA_W-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== exp_val) begin
            $error("register %s: expected %0d, got %0d", idx.name(), exp_val, got);
            reg_errors++;
        end
    endtask

    // config changes only once every outstanding result has drained
    task automatic wait_idle();
        while (sample_queue.size() > 0 || tracker.outstanding() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apply_setting(input int len, input int thr, input int mode);
        wait_idle();
        reg_write(wat_pkg::REG_LEN, wat_pkg::CFG_DATA_W'(len));
        reg_write(wat_pkg::REG_THR, wat_pkg::CFG_DATA_W'(thr));
        reg_write(wat_pkg::REG_MODE, wat_pkg::CFG_DATA_W'(mode));
        reg_check(wat_pkg::REG_LEN, wat_pkg::CFG_DATA_W'(len & 32'h1FFF));
        reg_check(wat_pkg::REG_THR, wat_pkg::CFG_DATA_W'(thr & 32'h7FFF));
        reg_check(wat_pkg::REG_MODE, wat_pkg::CFG_DATA_W'(mode & 1));
        settings_used++;
    endtask

    function automatic t_sample make_sample(int level);
        int v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = 32767;
                    1:       v = -32768;
                    2:       v = 0;
                    3:       v = 1;
                    default: v = -1;
                endcase
            end
            1, 2, 3, 4: v = int'($urandom_range(0, 65535)) - 32768;
            default:    v = level + int'($urandom_range(0, 512)) - 256;
        endcase
        if (v > 32767)  v = 32767;
        if (v < -32768) v = -32768;
        return t_sample'(v);
    endfunction

    initial begin
        int phase_count;
        int random_total;
        int len_val;
        int thr_val;
        int mode_val;
        int n_items;
        int level;

        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        smp_if.valid   = 1'b0;
        smp_if.sample  = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        reg_check(wat_pkg::REG_LEN, wat_pkg::CFG_DATA_W'(wat_pkg::LEN_RST));
        reg_check(wat_pkg::REG_THR, wat_pkg::CFG_DATA_W'(wat_pkg::THR_RST));
        reg_check(wat_pkg::REG_MODE, wat_pkg::CFG_DATA_W'(wat_pkg::MODE_RST));

        // directed: extremes, truncation, threshold equality, len 0, most negative mean
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        apply_setting(1, 32767, 1);
        sample_queue = '{32767, 1, 0, -1, -32767};
        feed_samples();
        apply_setting(2, 32767, 1);
        sample_queue = '{32767, 32767, -32768, -32767, 1, -2};
        feed_samples();
        apply_setting(1, 100, 1);
        sample_queue = '{100, -100};
        feed_samples();
        apply_setting(0, 100, 0);
        sample_queue = '{100, -100, -32768};
        feed_samples();
        apply_setting(1, 32767, 0);
        sample_queue = '{-32768, 32767};
        feed_samples();
        apply_setting(3, 0, 0);
        sample_queue = '{5, -7, 2, 0, 4};
        feed_samples();

        phase_count  = 0;
        random_total = 0;
        while (random_total < 1100) begin
            level = int'($urandom_range(0, 65535)) - 32768;
            if (phase_count == 3) begin
                // oversize length write, saturates to the largest window
                len_val        = 8191;
                thr_val        = 0;
                mode_val       = 0;
                n_items        = 60;
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end else begin
                case ($urandom_range(0, 19))
                    0:                  len_val = 0;
                    1, 19:              len_val = 1;
                    14, 15, 16, 17:     len_val = $urandom_range(9, 64);
                    18:                 len_val = $urandom_range(65, 300);
                    default:            len_val = $urandom_range(2, 8);
                endcase
                if (random_total < 500) begin
                    // extreme thresholds: early on only a mean of -32768 in above mode sets the sticky flag
                    mode_val = $urandom_range(0, 1);
                    thr_val  = mode_val ? 32767 : 0;
                end else begin
                    mode_val = $urandom_range(0, 1);
                    case ($urandom_range(0, 3))
                        0:       thr_val = 0;
                        1:       thr_val = 32767;
                        2:       thr_val = $urandom_range(0, 32767);
                        default: thr_val = (level < 0) ? -level - 1 : level;
                    endcase
                    if (thr_val > 32767) thr_val = 32767;
                end
                n_items = ((len_val == 0) ? 1 : len_val) + $urandom_range(10, 80);
                case ($urandom_range(0, 3))
                    0:       send_idle_pct = 0;
                    1:       send_idle_pct = 10;
                    2:       send_idle_pct = 30;
                    default: send_idle_pct = 60;
                endcase
                case ($urandom_range(0, 3))
                    0:       recv_stall_pct = 0;
                    1:       recv_stall_pct = 10;
                    2:       recv_stall_pct = 30;
                    default: recv_stall_pct = 60;
                endcase
            end
            random_total += n_items;
            apply_setting(len_val, thr_val, mode_val);
            repeat (n_items) sample_queue.insert(sample_queue.size(), make_sample(level));
            if (phase_count == 1) begin
                hold_off_req = 1;
            end
            feed_samples();
            phase_count++;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("covered %0d samples (%0d means) over %0d register settings, lengths 0..8191",
                 tracker.samples_taken, tracker.means_taken, settings_used);
        $display("both threshold modes, long output hold-off; event flag ended at %0b",
                 tracker.event_hit);
        if (tracker.mismatches == 0 && reg_errors == 0 && tracker.outstanding() == 0) begin
            $display("windowed_average_threshold_detector verification clean");
        end else begin
            $display("windowed_average_threshold_detector verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/wat_pkg.sv
design/wat_if.sv
design/wat_regs.sv
design/wat_ctrl.sv
design/wat_dp.sv
design/windowed_average_threshold_detector.sv
tb/tb_windowed_average_threshold_detector.sv
